/* src/svtc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package svtc_pkg;

  localparam int unsigned TagW = 20;
  localparam int unsigned SetW = 7;
  localparam int unsigned WayW = 3;
  localparam int unsigned NumWays = 8;
  localparam int unsigned PlruW = 7;

  localparam logic [2:0] OP_CPU_RD = 3'd0;
  localparam logic [2:0] OP_CPU_WR = 3'd1;
  localparam logic [2:0] OP_SN_RD = 3'd2;
  localparam logic [2:0] OP_SN_WR = 3'd3;
  localparam logic [2:0] OP_SN_RDX = 3'd4;
  localparam logic [2:0] OP_BUS_IDLE = 3'd5;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_BUSRD = 2'd1;
  localparam logic [1:0] CMD_BUSWR = 2'd2;
  localparam logic [1:0] CMD_BUSRDX = 2'd3;

  typedef enum logic [1:0] {
    K_NOP,
    K_CPU_RD,
    K_CPU_WR,
    K_SNOOP
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic inv;
    logic [TagW-1:0] tag;
    logic [SetW-1:0] set;
  } req_t;

  localparam logic [6:0] SEL_MASK [NumWays] = '{7'h0B, 7'h0B, 7'h13, 7'h13,
                                                7'h25, 7'h25, 7'h45, 7'h45};
  localparam logic [6:0] SEL_VAL [NumWays] = '{7'h00, 7'h08, 7'h02, 7'h12,
                                               7'h01, 7'h21, 7'h05, 7'h45};
  localparam logic [6:0] SET_BITS [NumWays] = '{7'h0B, 7'h03, 7'h11, 7'h01,
                                                7'h24, 7'h04, 7'h40, 7'h00};
  localparam logic [6:0] KEEP_BITS [NumWays] = '{7'h7F, 7'h77, 7'h7D, 7'h6D,
                                                 7'h7E, 7'h5E, 7'h7A, 7'h3A};

endpackage
`default_nettype wire

/* src/snooping_vi_cache_tag_controller_unit.sv */
// Tag and state controller of an 8-way, 128-set write-through cache with
// valid-invalid snooping and tree pseudo-LRU replacement.
// The input channel takes op, addr and requester_id under valid_i and stall_o.
// Every accepted item yields exactly one result item on the output channel
// (hit, way_used, bus_command, invalidated) under valid_o and stall_i.
// A front decoder classifies each item into a two-entry queue; the back end
// reads the eight tags of the set from the single-port tag memory, one way
// per cycle, then resolves and updates the set.
// Results are registered after the tag reads and the resolve; the back end
// handles one item at a time, while the queue accepts further items.
// The own_id register is written with cfg_we_i and cfg_data_i; the user
// must write it while idle, as the block itself does not enforce this.
// Reset clears the queue and own_id, then a clearing pass over all 128 sets
// zeroes the valid and pseudo-LRU bits; items are queued but not executed
// during the pass. Tag memory contents are ignored until a way is valid.
// When the receiver stalls, the result holds and the queue fills, after
// which stall_o rises.
`timescale 1ns / 1ps
`default_nettype none
module snooping_vi_cache_tag_controller_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [3:0] cfg_data_i,
  input  wire logic valid_i,
  output logic stall_o,
  input  wire logic [2:0] op_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [3:0] requester_id_i,
  output logic valid_o,
  input  wire logic stall_i,
  output logic hit_o,
  output logic [2:0] way_used_o,
  output logic [1:0] bus_command_o,
  output logic invalidated_o
);
  logic [3:0] own_id_q;
  svtc_pkg::req_t front_req, queue_req;
  logic full, empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) own_id_q <= '0;
    else if (cfg_we_i) own_id_q <= cfg_data_i;
  end

  svtc_front u_front (
    .op_i(op_i), .addr_i(addr_i), .requester_id_i(requester_id_i),
    .own_id_i(own_id_q), .req_o(front_req)
  );

  assign stall_o = full;

  svtc_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(valid_i && !full), .data_i(front_req),
    .full_o(full), .empty_o(empty), .pop_i(pop), .data_o(queue_req)
  );

  svtc_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(!empty), .req_i(queue_req),
    .req_pop_o(pop), .valid_o(valid_o), .stall_i(stall_i), .hit_o(hit_o),
    .way_used_o(way_used_o), .bus_command_o(bus_command_o),
    .invalidated_o(invalidated_o)
  );
endmodule
`default_nettype wire

/* src/svtc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module svtc_front (
  input  wire logic [2:0] op_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [3:0] requester_id_i,
  input  wire logic [3:0] own_id_i,
  output svtc_pkg::req_t req_o
);
  always_comb begin
    req_o.tag = addr_i[31:12];
    req_o.set = addr_i[11:5];
    req_o.inv = 1'b0;
    req_o.kind = svtc_pkg::K_NOP;
    unique case (op_i) inside
      svtc_pkg::OP_CPU_RD: req_o.kind = svtc_pkg::K_CPU_RD;
      svtc_pkg::OP_CPU_WR: req_o.kind = svtc_pkg::K_CPU_WR;
      svtc_pkg::OP_SN_RD, svtc_pkg::OP_SN_WR, svtc_pkg::OP_SN_RDX: begin
        if (requester_id_i != own_id_i) begin
          req_o.kind = svtc_pkg::K_SNOOP;
          req_o.inv = (op_i != svtc_pkg::OP_SN_RD);
        end
      end
      default: req_o.kind = svtc_pkg::K_NOP;
    endcase
  end
endmodule
`default_nettype wire

/* src/svtc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module svtc_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  svtc_pkg::req_t data_i,
  output logic full_o,
  output logic empty_o,
  input  wire logic pop_i,
  output svtc_pkg::req_t data_o
);
  svtc_pkg::req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
endmodule
`default_nettype wire

/* src/svtc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module svtc_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  input  svtc_pkg::req_t req_i,
  output logic req_pop_o,
  output logic valid_o,
  input  wire logic stall_i,
  output logic hit_o,
  output logic [2:0] way_used_o,
  output logic [1:0] bus_command_o,
  output logic invalidated_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  localparam int unsigned Depth = 1 << (svtc_pkg::SetW + svtc_pkg::WayW);
  localparam int unsigned NumSets = 1 << svtc_pkg::SetW;
  localparam int unsigned MetaW = svtc_pkg::PlruW + svtc_pkg::NumWays;

  logic [1:0] state_q, state_d;
  logic [svtc_pkg::TagW-1:0] tag_mem [Depth];
  logic [svtc_pkg::TagW-1:0] rd_tag_q [svtc_pkg::NumWays];
  logic [svtc_pkg::WayW-1:0] rd_way_q;
  logic [MetaW-1:0] meta_mem [NumSets];
  logic [svtc_pkg::NumWays-1:0] vrow_q, valid_nxt;
  logic [svtc_pkg::PlruW-1:0] prow_q, plru_nxt;
  logic [svtc_pkg::SetW-1:0] clr_q;
  svtc_pkg::req_t cur_q;
  logic [svtc_pkg::NumWays-1:0] match;
  logic [svtc_pkg::WayW-1:0] hit_way, victim, way_sel;
  logic any_hit, wr_en, meta_we;
  logic [svtc_pkg::PlruW-1:0] plru_cur;

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) rd_tag_q[rd_way_q] <= tag_mem[{cur_q.set, rd_way_q}];
    if (wr_en) tag_mem[{cur_q.set, way_sel}] <= cur_q.tag;
  end

  // Valid and pseudo-LRU bits of a set share one word; the row is read
  // while the tags are read and written back when a CPU item or an invalidating snoop executes.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) meta_mem[clr_q] <= '0;
    else if (meta_we) meta_mem[cur_q.set] <= {plru_nxt, valid_nxt};
    if (state_q == S_READ) {prow_q, vrow_q} <= meta_mem[cur_q.set];
  end

  assign plru_cur = prow_q;

  always_comb begin
    for (int w = 0; w < svtc_pkg::NumWays; w++) begin
      match[w] = vrow_q[w] && (rd_tag_q[w] == cur_q.tag);
    end
    any_hit = |match;
    hit_way = '0;
    for (int w = svtc_pkg::NumWays - 1; w >= 0; w--) begin
      if (match[w]) hit_way = svtc_pkg::WayW'(w);
    end
    victim = '0;
    for (int w = svtc_pkg::NumWays - 1; w >= 0; w--) begin
      if ((plru_cur & svtc_pkg::SEL_MASK[w]) == svtc_pkg::SEL_VAL[w]) begin
        victim = svtc_pkg::WayW'(w);
      end
    end
    way_sel = any_hit ? hit_way : victim;
  end

  logic exec_go, is_cpu;
  assign exec_go = (state_q == S_EXEC) && (!valid_o || !stall_i);
  assign is_cpu = (cur_q.kind == svtc_pkg::K_CPU_RD) || (cur_q.kind == svtc_pkg::K_CPU_WR);
  assign wr_en = exec_go && is_cpu && !any_hit;
  assign req_pop_o = (state_q == S_IDLE) && req_valid_i;
  assign meta_we = exec_go && (is_cpu || (cur_q.kind == svtc_pkg::K_SNOOP && cur_q.inv));

  always_comb begin
    valid_nxt = vrow_q;
    plru_nxt = prow_q;
    if (is_cpu) begin
      plru_nxt = (plru_cur | svtc_pkg::SET_BITS[way_sel]) & svtc_pkg::KEEP_BITS[way_sel];
      if (!any_hit) begin
        valid_nxt = vrow_q | ({{(svtc_pkg::NumWays - 1){1'b0}}, 1'b1} << way_sel);
      end
    end else begin
      valid_nxt = vrow_q & ~match;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: if (req_valid_i) state_d = S_READ;
      S_READ: if (rd_way_q == svtc_pkg::WayW'(svtc_pkg::NumWays - 1)) state_d = S_EXEC;
      S_EXEC: if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) cur_q <= req_i;
    if (exec_go) begin
      hit_o <= 1'b0;
      way_used_o <= '0;
      bus_command_o <= svtc_pkg::CMD_NONE;
      invalidated_o <= 1'b0;
      case (cur_q.kind)
        svtc_pkg::K_CPU_RD: begin
          hit_o <= any_hit;
          way_used_o <= way_sel;
          bus_command_o <= any_hit ? svtc_pkg::CMD_NONE : svtc_pkg::CMD_BUSRD;
        end
        svtc_pkg::K_CPU_WR: begin
          hit_o <= any_hit;
          way_used_o <= way_sel;
          bus_command_o <= any_hit ? svtc_pkg::CMD_BUSWR : svtc_pkg::CMD_BUSRDX;
        end
        svtc_pkg::K_SNOOP: begin
          hit_o <= any_hit;
          invalidated_o <= cur_q.inv && any_hit;
        end
        default: hit_o <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rd_way_q <= '0;
      clr_q <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_READ) rd_way_q <= rd_way_q + 1'b1;
      if (exec_go) valid_o <= 1'b1;
      else if (!stall_i) valid_o <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> state_q == S_READ)
    else $error("lookup did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> rd_way_q == '0)
    else $error("tag read incomplete");
endmodule
`default_nettype wire

/* verif/tb_snooping_vi_cache_tag_controller_unit.sv */
`timescale 1ns / 1ps
module tb_snooping_vi_cache_tag_controller_unit;

  typedef struct packed {
    logic       hit;
    logic [2:0] way;
    logic [1:0] cmd;
    logic       inval;
  } lookup_res_t;

  class tag_scoreboard;
    logic [19:0] tags [1024];
    logic        valid [1024];
    logic [6:0]  plru [128];
    logic [3:0]  own_id;
    lookup_res_t pending [$];
    int          mismatches;

    function void clear();
      for (int i = 0; i < 1024; i++) begin
        tags[i] = '1;
        valid[i] = 1'b0;
      end
      for (int i = 0; i < 128; i++) plru[i] = '0;
      own_id = '0;
      mismatches = 0;
      pending.delete();
    endfunction

    function void note_item(logic [2:0] op, logic [31:0] addr, logic [3:0] req);
      lookup_res_t r;
      logic [6:0] set;
      logic [19:0] tag;
      int found;
      int w;
      r = '0;
      set = addr[11:5];
      tag = addr[31:12];
      found = -1;
      for (int i = 7; i >= 0; i--)
        if (valid[set*8+i] && tags[set*8+i] == tag) found = i;
      if (op == svtc_pkg::OP_CPU_RD || op == svtc_pkg::OP_CPU_WR) begin
        if (found >= 0) begin
          r.hit = 1'b1;
          w = found;
          r.cmd = (op == svtc_pkg::OP_CPU_RD) ? svtc_pkg::CMD_NONE : svtc_pkg::CMD_BUSWR;
        end else begin
          w = 0;
          for (int i = 7; i >= 0; i--)
            if ((plru[set] & svtc_pkg::SEL_MASK[i]) == svtc_pkg::SEL_VAL[i]) w = i;
          tags[set*8+w] = tag;
          valid[set*8+w] = 1'b1;
          r.cmd = (op == svtc_pkg::OP_CPU_RD) ? svtc_pkg::CMD_BUSRD : svtc_pkg::CMD_BUSRDX;
        end
        r.way = w[2:0];
        plru[set] = (plru[set] | svtc_pkg::SET_BITS[w]) & svtc_pkg::KEEP_BITS[w];
      end else if ((op == svtc_pkg::OP_SN_RD || op == svtc_pkg::OP_SN_WR ||
                    op == svtc_pkg::OP_SN_RDX) && req != own_id) begin
        r.hit = (found >= 0);
        if (op != svtc_pkg::OP_SN_RD)
          for (int i = 0; i < 8; i++)
            if (valid[set*8+i] && tags[set*8+i] == tag) begin
              valid[set*8+i] = 1'b0;
              r.inval = 1'b1;
            end
      end
      pending.push_back(r);
    endfunction

    function void check_result(lookup_res_t got);
      lookup_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (e !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch exp %p got %p", e, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i, valid_i, stall_i;
  logic [3:0] cfg_data_i, requester_id_i;
  logic [2:0] op_i;
  logic [31:0] addr_i;
  logic stall_o, valid_o, hit_o, invalidated_o;
  logic [2:0] way_used_o;
  logic [1:0] bus_command_o;
  tag_scoreboard sb;
  int cycles;
  bit hold_rx;
  bit quiet_rx;

  snooping_vi_cache_tag_controller_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .valid_i, .stall_o, .op_i, .addr_i,
    .requester_id_i, .valid_o, .stall_i, .hit_o, .way_used_o, .bus_command_o,
    .invalidated_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL snooping_vi_cache_tag_controller_unit");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      sb.check_result('{hit_o, way_used_o, bus_command_o, invalidated_o});
  end

  initial begin : rx_proc
    int n;
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
        stall_i <= 1'b0;
      end else if (!quiet_rx) begin
        n = $urandom_range(0, 16);
        if (($urandom_range(0, 3) == 0) || n == 0) stall_i <= 1'b0;
        else begin
          stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          stall_i <= 1'b0;
        end
      end else stall_i <= 1'b0;
    end
  end

  bit quiet_tx;

  task automatic send_item(logic [2:0] op, logic [31:0] addr, logic [3:0] req);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    op_i <= op;
    addr_i <= addr;
    requester_id_i <= req;
    sb.note_item(op, addr, req);
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic drain_and_config(logic [3:0] id);
    valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.own_id = id;
  endtask

  function automatic logic [31:0] pick_addr(logic [6:0] set);
    logic [31:0] a;
    a = $urandom;
    a[11:5] = set;
    a[31:12] = 20'hA5000 | 20'($urandom_range(0, 11));
    return a;
  endfunction

  initial begin
    logic [3:0] ids [4];
    logic [2:0] op;
    logic [31:0] a;
    sb = new();
    sb.clear();
    cycles = 0;
    hold_rx = 1'b0;
    quiet_rx = 1'b0;
    quiet_tx = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    valid_i = 1'b0;
    op_i = '0;
    addr_i = '0;
    requester_id_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drain_and_config(4'd0);
    send_item(svtc_pkg::OP_CPU_RD, 32'h0000_0000, 4'd0);
    send_item(svtc_pkg::OP_CPU_RD, 32'h0000_0000, 4'd0);
    send_item(svtc_pkg::OP_CPU_WR, 32'hFFFF_FFFF, 4'd15);
    send_item(svtc_pkg::OP_CPU_WR, 32'hFFFF_FFFF, 4'd0);
    send_item(svtc_pkg::OP_SN_RD, 32'hFFFF_FFFF, 4'd3);
    send_item(svtc_pkg::OP_SN_WR, 32'hFFFF_FFFF, 4'd0);
    send_item(svtc_pkg::OP_SN_WR, 32'hFFFF_FFFF, 4'd5);
    send_item(svtc_pkg::OP_SN_RDX, 32'h0000_0000, 4'd15);
    send_item(svtc_pkg::OP_SN_RDX, 32'h0000_0000, 4'd15);
    for (int i = 0; i < 9; i++)
      send_item(svtc_pkg::OP_CPU_RD, {20'(i), 7'd3, 5'd0}, 4'd0);
    send_item(svtc_pkg::OP_BUS_IDLE, 32'h0000_0060, 4'd1);
    send_item(3'd6, 32'h0000_0060, 4'd1);
    send_item(3'd7, 32'hFFFF_FFFF, 4'd2);
    drain_and_config(4'd15);
    ids = '{4'd15, 4'd7, 4'd0, 4'd15};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) hold_rx = 1'b1;
      quiet_rx = (ph == 2);
      quiet_tx = (ph == 2);
      for (int k = 0; k < 350; k++) begin
        op = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 7));
        if ($urandom_range(0, 9) == 0) a = $urandom;
        else a = pick_addr(7'($urandom_range(0, 3)));
        send_item(op, a, ($urandom_range(0, 1)) ? sb.own_id : 4'($urandom));
      end
      drain_and_config(ids[ph]);
    end
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0) $display("PASS snooping_vi_cache_tag_controller_unit");
    else $display("FAIL snooping_vi_cache_tag_controller_unit");
    $finish;
  end
endmodule

/* snooping_vi_cache_tag_controller_unit.f */
src/svtc_pkg.sv
src/svtc_front.sv
src/svtc_queue.sv
src/svtc_back.sv
src/snooping_vi_cache_tag_controller_unit.sv
verif/tb_snooping_vi_cache_tag_controller_unit.sv
